/* rtl/dpwp_pkg.sv */
// Package for the dual priority work picker.
// Holds the slot count, field widths, the command codes and the control structs.
// No dependencies.
package dpwp_pkg;

  localparam int NODE_SLOTS = 64;
  localparam int SLOT_W     = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;
  localparam int ID_W       = 6;
  localparam int USED_W     = 32;
  localparam int LEVEL_W    = 16;

  typedef enum logic [1:0] {
    CMD_PLAN    = 2'd0,
    CMD_REMOVE  = 2'd1,
    CMD_PEEK    = 2'd2,
    CMD_RELEASE = 2'd3
  } dpwp_op_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;        // capture the input word
    logic apply;       // perform plan, remove or release
    logic scan_clear;  // restart the scan and drop the best candidate
    logic scan_step;   // read one slot and advance
    logic commit;      // load the result register, mark the pick busy
  } dpwp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_peek;
    logic scan_last;
  } dpwp_stat_t;

endpackage

/* rtl/dpwp_ctrl.sv */
// Controller state machine of the dual priority work picker.
// Sequences accept, update or scan, and result hand-off; uses dpwp_pkg.
module dpwp_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  dpwp_pkg::dpwp_stat_t stat,
  output dpwp_pkg::dpwp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_SCAN,
    S_FLUSH,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next     = state;
    cmd            = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        if (stat.is_peek) begin
          cmd.scan_clear = 1'b1;
          state_next     = S_SCAN;
        end else begin
          cmd.apply  = 1'b1;
          state_next = S_FINISH;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        // The compare stage takes the last slot during this cycle.
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    out_valid_next = (out_valid && !out_ready) || cmd.commit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  a_scan_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && stat.scan_last) |=> (state == S_FLUSH))
    else $error("scan did not hand over to the flush cycle");

  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("committed result not presented");

endmodule

/* rtl/dpwp_datapath.sv */
// Datapath of the dual priority work picker: input register, membership and
// busy flags, key memories, the slot scan with its compare stage, result register.
// Uses dpwp_pkg.
module dpwp_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  dpwp_pkg::dpwp_cmd_t                 cmd,
  output dpwp_pkg::dpwp_stat_t                stat,
  input  logic [1:0]                          command,
  input  logic [dpwp_pkg::ID_W-1:0]           node_id,
  input  logic                                use_branch,
  input  logic                                use_merge,
  input  logic [dpwp_pkg::USED_W-1:0]         index_used,
  input  logic [dpwp_pkg::LEVEL_W-1:0]        level,
  input  logic                                queue_select,
  input  logic [dpwp_pkg::USED_W-1:0]         watermark,
  output logic                                picked,
  output logic [dpwp_pkg::ID_W-1:0]           picked_id
);

  // Captured input word.
  dpwp_pkg::dpwp_op_t                 cmd_q;
  logic [dpwp_pkg::ID_W-1:0]          id_q;
  logic                               ub_q;
  logic                               um_q;
  logic [dpwp_pkg::USED_W-1:0]        iused_q;
  logic [dpwp_pkg::LEVEL_W-1:0]       lv_q;
  logic                               qsel_q;
  logic [dpwp_pkg::USED_W-1:0]        wm_q;

  logic [dpwp_pkg::NODE_SLOTS-1:0]    in_branch;
  logic [dpwp_pkg::NODE_SLOTS-1:0]    in_merge;
  logic [dpwp_pkg::NODE_SLOTS-1:0]    busy_b;
  logic [dpwp_pkg::NODE_SLOTS-1:0]    busy_m;

  logic [dpwp_pkg::USED_W-1:0]        used_mem  [dpwp_pkg::NODE_SLOTS];
  logic [dpwp_pkg::LEVEL_W-1:0]       level_mem [dpwp_pkg::NODE_SLOTS];
  logic [dpwp_pkg::USED_W-1:0]        used_rd;
  logic [dpwp_pkg::LEVEL_W-1:0]       level_rd;

  logic [dpwp_pkg::SLOT_W-1:0]        addr_q;      // slot of the input word
  logic                               slot_ok;
  logic [dpwp_pkg::SLOT_W-1:0]        scan_addr;
  logic [dpwp_pkg::SLOT_W-1:0]        stage_id;
  logic                               stage_v;
  logic                               stage_elig;
  logic                               elig;
  logic [dpwp_pkg::USED_W-1:0]        stage_key;
  logic                               best_valid;
  logic [dpwp_pkg::SLOT_W-1:0]        best_id;
  logic [dpwp_pkg::USED_W-1:0]        best_key;
  logic                               take;
  logic                               pick_ok;
  logic                               do_plan;
  logic                               do_remove;
  logic                               do_release;

  assign addr_q  = dpwp_pkg::SLOT_W'(id_q);
  assign slot_ok = (32'(id_q) < 32'(dpwp_pkg::NODE_SLOTS));

  assign do_plan    = cmd.apply && slot_ok && (cmd_q == dpwp_pkg::CMD_PLAN);
  assign do_remove  = cmd.apply && slot_ok && (cmd_q == dpwp_pkg::CMD_REMOVE);
  assign do_release = cmd.apply && slot_ok && (cmd_q == dpwp_pkg::CMD_RELEASE);

  assign stat.is_peek   = (cmd_q == dpwp_pkg::CMD_PEEK);
  assign stat.scan_last = (scan_addr == dpwp_pkg::SLOT_W'(dpwp_pkg::NODE_SLOTS - 1));

  // A node busy for either queue is passed over by both.
  assign elig = (qsel_q ? in_merge[scan_addr] : in_branch[scan_addr])
                && !busy_b[scan_addr] && !busy_m[scan_addr];

  assign stage_key = qsel_q ? dpwp_pkg::USED_W'(level_rd) : used_rd;
  // Ascending scan with >= so that the larger slot wins a tie.
  assign take      = stage_v && stage_elig && (!best_valid || stage_key >= best_key);
  assign pick_ok   = stat.is_peek && best_valid && (best_key >= wm_q);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_q   <= dpwp_pkg::dpwp_op_t'(command);
      id_q    <= node_id;
      ub_q    <= use_branch;
      um_q    <= use_merge;
      iused_q <= index_used;
      lv_q    <= level;
      qsel_q  <= queue_select;
      wm_q    <= watermark;
    end
  end

  always_ff @(posedge clk) begin
    if (do_plan && ub_q) begin
      used_mem[addr_q] <= iused_q;
    end
    used_rd <= used_mem[scan_addr];
  end

  always_ff @(posedge clk) begin
    if (do_plan && um_q) begin
      level_mem[addr_q] <= lv_q;
    end
    level_rd <= level_mem[scan_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_branch <= '0;
      in_merge  <= '0;
      busy_b    <= '0;
      busy_m    <= '0;
    end else begin
      if (do_plan && ub_q) begin
        in_branch[addr_q] <= 1'b1;
      end
      if (do_plan && um_q) begin
        in_merge[addr_q] <= 1'b1;
      end
      if (do_remove && ub_q) begin
        in_branch[addr_q] <= 1'b0;
      end
      if (do_remove && um_q) begin
        in_merge[addr_q] <= 1'b0;
      end
      if (do_release) begin
        busy_b[addr_q] <= 1'b0;
        busy_m[addr_q] <= 1'b0;
      end
      if (cmd.commit && pick_ok) begin
        if (qsel_q) begin
          busy_m[best_id] <= 1'b1;
        end else begin
          busy_b[best_id] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_addr  <= '0;
      stage_v    <= 1'b0;
      best_valid <= 1'b0;
    end else begin
      stage_v <= cmd.scan_step;
      if (cmd.scan_clear) begin
        scan_addr  <= '0;
        best_valid <= 1'b0;
      end else begin
        if (cmd.scan_step) begin
          scan_addr <= scan_addr + 1'b1;
        end
        if (take) begin
          best_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step) begin
      stage_elig <= elig;
      stage_id   <= scan_addr;
    end
    if (take) begin
      best_id  <= stage_id;
      best_key <= stage_key;
    end
    if (cmd.commit) begin
      picked    <= pick_ok;
      picked_id <= pick_ok ? dpwp_pkg::ID_W'(best_id) : '0;
    end
  end

  a_pick_marks_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && pick_ok) |=>
      ($past(qsel_q) ? busy_m[$past(best_id)] : busy_b[$past(best_id)]))
    else $error("picked node was not marked busy");

  a_clear_drops_best: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_clear |=> (!best_valid && scan_addr == '0))
    else $error("scan restart left a stale candidate");

endmodule

/* rtl/dual_priority_work_picker.sv */
// Top level of the dual priority work picker.
// Joins the controller dpwp_ctrl and the datapath dpwp_datapath; uses dpwp_pkg.
//
//   channel  handshake            fields
//   input    in_valid/in_ready    command node_id use_branch use_merge index_used
//                                 level queue_select watermark
//   output   out_valid/out_ready  picked picked_id
//
// Plan, remove and release are applied in the start state and committed in the finish state.
// A peek scans every slot: the scan reads one slot per cycle from the
// single read port of the key memories, then a flush state and a finish state follow.
// One word is worked on at a time; the next is accepted once the result is loaded
// into the output register, even while that result still waits for out_ready.
// Reset (rst, synchronous) empties both queues and clears every busy mark.
module dual_priority_work_picker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    command,
  input  logic [dpwp_pkg::ID_W-1:0]     node_id,
  input  logic                          use_branch,
  input  logic                          use_merge,
  input  logic [dpwp_pkg::USED_W-1:0]   index_used,
  input  logic [dpwp_pkg::LEVEL_W-1:0]  level,
  input  logic                          queue_select,
  input  logic [dpwp_pkg::USED_W-1:0]   watermark,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          picked,
  output logic [dpwp_pkg::ID_W-1:0]     picked_id
);

  dpwp_pkg::dpwp_cmd_t  cmd;
  dpwp_pkg::dpwp_stat_t stat;

  dpwp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  dpwp_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .command      (command),
    .node_id      (node_id),
    .use_branch   (use_branch),
    .use_merge    (use_merge),
    .index_used   (index_used),
    .level        (level),
    .queue_select (queue_select),
    .watermark    (watermark),
    .picked       (picked),
    .picked_id    (picked_id)
  );

endmodule
